// ===== design/sccc_pkg.sv =====
// Shared types and constants for the subset cycle cover counter.
// Holds stream and register field widths, the command codes and register indexes.
// No dependencies.
package sccc_pkg;

    // Request field widths.
    localparam int CMD_W    = 2;
    localparam int VERTEX_W = 3;
    localparam int ROW_W    = 8;
    localparam int QUERY_W  = 8;
    localparam int COUNT_W  = 64;

    // Packed stream widths.
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = CMD_W;
    localparam int M_TDATA_W = COUNT_W;

    // Bit positions of the fields inside the input tdata.
    localparam int VERTEX_LSB = 0;
    localparam int ROW_LSB    = VERTEX_LSB + VERTEX_W;
    localparam int QUERY_LSB  = ROW_LSB + ROW_W;

    // Register port.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam int VC_W   = 4;

    // Register index, taken from paddr bit 2 (one register, 4-byte stride).
    localparam logic REG_VERTEX_COUNT = 1'b0;
    localparam logic [VC_W-1:0] VC_RESET = 4'd8;

    // Command codes carried in tuser.
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_RUN   = 2'd1,
        CMD_QUERY = 2'd2
    } t_cmd;

endpackage

// ===== design/subset_cycle_cover_counter_top.sv =====
// Subset cycle cover counter: top level with sequencer, shared adder and multiplier.
// Depends on sccc_pkg and sccc_ram.
//
// Usage:
// The input stream carries one request per transfer. tuser holds the command:
// load an adjacency row, run the counting pass, or answer a split query.
// Only a query produces a result on the output stream (the 64-bit count).
// The vertex count register sits at byte address 0 of the register port; the user
// is to write it only while the block is idle. The block itself does not enforce this.
// Behaviour per request (M = MAX_VERTICES):
//   load: the block stays ready.
//   run: a clearing sweep over all 2^(M + ceil(log2 M)) path store entries
//   (2048 for M = 8), then the dynamic program, in which every update is a
//   read-modify-write through one shared 64-bit adder on a memory with one
//   read and one write port.
//   query: a single count goes straight to the output register; a product
//   goes through one 32x32 multiplier over three passes.
// Reset clears the stores with the same sweep; s_axis_tready stays low meanwhile.
// When the receiver stalls, the result waits in the output register; the block
// takes further loads and runs, and a next query holds until the register frees.
module subset_cycle_cover_counter_top
    import sccc_pkg::*;
#(
    parameter int MAX_VERTICES = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: vertex[2:0], row_bits[10:3], query_mask[18:11], zero fill.
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // tuser: command[1:0].
    input  logic [S_TUSER_W-1:0]  s_axis_tuser,
    // Output stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: count[63:0].
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    // Register port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready
);

    localparam int LW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int VW = $clog2(MAX_VERTICES + 1);
    localparam int PATH_AW = MAX_VERTICES + LW;
    localparam int PATH_DEPTH = 1 << PATH_AW;
    localparam int SETS = 1 << MAX_VERTICES;
    localparam int EXT_W = (MAX_VERTICES > ROW_W) ? MAX_VERTICES : ROW_W;

    typedef logic [MAX_VERTICES-1:0] t_set;
    typedef logic [LW-1:0] t_vidx;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_INIT, S_WAYS_RD, S_WAYS_LD, S_J, S_J_WR, S_C_WR,
        S_LAST, S_KLD, S_K, S_K_WR, S_NEXT, S_QA, S_QB, S_QC,
        S_M1, S_M2, S_M3, S_M4, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic r_go_init, n_go_init;
    logic [PATH_AW-1:0] r_clr, n_clr;
    logic [VC_W-1:0] r_vc, n_vc;
    t_set r_adj [MAX_VERTICES];
    t_set n_adj [MAX_VERTICES];
    t_vidx r_top, n_top, r_last, n_last, r_j, n_j, r_k, n_k;
    t_set r_sub, n_sub, r_row, n_row, r_first, n_first, r_second, n_second;
    logic [COUNT_W-1:0] r_ways, n_ways, r_opa, n_opa, r_opb, n_opb;
    logic [COUNT_W-1:0] r_prod, n_prod, r_acc, n_acc, r_m_data, n_m_data;
    logic r_m_valid, n_m_valid;

    // Memory ports.
    logic               p_we, p_re, c_we, c_re;
    logic [PATH_AW-1:0] p_waddr, p_raddr;
    logic [COUNT_W-1:0] p_wdata, p_rdata, c_wdata, c_rdata;
    t_set               c_waddr, c_raddr;

    // Shared adder and multiplier.
    logic [COUNT_W-1:0] add_a, add_b, add_sum;
    logic [31:0]        mul_a, mul_b;
    logic [COUNT_W-1:0] mul_p;

    // Decoded request and derived values.
    logic            s_fire;
    t_cmd            cmd;
    logic [EXT_W-1:0] row_ext, query_ext;
    t_set            row_in, query_in, all_set, q_first, q_second, sub_full;
    logic [VW-1:0]   n_used, n_m1;
    logic [COUNT_W-1:0] prod_shift;
    logic [PATH_AW-1:0] j_addr, k_addr;

    sccc_ram #(.WIDTH(COUNT_W), .DEPTH(PATH_DEPTH)) u_path_ram (
        .i_clk  (i_clk),
        .i_we   (p_we),
        .i_waddr(p_waddr),
        .i_wdata(p_wdata),
        .i_re   (p_re),
        .i_raddr(p_raddr),
        .o_rdata(p_rdata)
    );

    sccc_ram #(.WIDTH(COUNT_W), .DEPTH(SETS)) u_cover_ram (
        .i_clk  (i_clk),
        .i_we   (c_we),
        .i_waddr(c_waddr),
        .i_wdata(c_wdata),
        .i_re   (c_re),
        .i_raddr(c_raddr),
        .o_rdata(c_rdata)
    );

    // Handshake and field decode.
    assign s_axis_tready = (r_state == S_IDLE);
    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign cmd = t_cmd'(s_axis_tuser);
    assign row_ext = EXT_W'(s_axis_tdata[ROW_LSB +: ROW_W]);
    assign query_ext = EXT_W'(s_axis_tdata[QUERY_LSB +: QUERY_W]);
    assign row_in = row_ext[MAX_VERTICES-1:0];
    assign query_in = query_ext[MAX_VERTICES-1:0];

    // Vertices in use, saturated to the build maximum.
    always_comb begin
        if (32'(r_vc) > MAX_VERTICES) begin
            n_used = VW'(MAX_VERTICES);
        end else begin
            n_used = VW'(r_vc);
        end
    end
    assign n_m1 = n_used - VW'(1);

    // Masks of in-use vertices, the split groups and the last subset of a top.
    always_comb begin
        for (int i = 0; i < MAX_VERTICES; i++) begin
            all_set[i] = (int'(n_used) > i);
            sub_full[i] = (int'(r_top) >= i);
        end
        q_first = query_in & all_set;
        q_second = all_set & ~q_first;
    end

    // Path store addresses for the neighbor and the next-anchor updates.
    assign j_addr = {r_sub | (t_set'(1) << r_j), r_j};
    assign k_addr = {r_sub | (t_set'(1) << r_k), r_k};

    // Shared 64-bit adder.
    assign prod_shift = {r_prod[31:0], 32'b0};
    always_comb begin
        case (r_state)
            S_M3, S_M4: begin
                add_a = r_acc;
                add_b = prod_shift;
            end
            S_C_WR: begin
                add_a = c_rdata;
                add_b = r_ways;
            end
            default: begin
                add_a = p_rdata;
                add_b = r_ways;
            end
        endcase
    end
    assign add_sum = add_a + add_b;

    // Shared 32x32 multiplier: low-by-low, low-by-high, high-by-low.
    always_comb begin
        case (r_state)
            S_M2: begin
                mul_a = r_opa[31:0];
                mul_b = r_opb[63:32];
            end
            S_M3: begin
                mul_a = r_opa[63:32];
                mul_b = r_opb[31:0];
            end
            default: begin
                mul_a = r_opa[31:0];
                mul_b = r_opb[31:0];
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Sequencer next state, memory control and register updates.
    always_comb begin
        n_state = r_state;
        n_go_init = r_go_init;
        n_clr = r_clr;
        n_vc = r_vc;
        n_adj = r_adj;
        n_top = r_top;
        n_last = r_last;
        n_j = r_j;
        n_k = r_k;
        n_sub = r_sub;
        n_row = r_row;
        n_first = r_first;
        n_second = r_second;
        n_ways = r_ways;
        n_opa = r_opa;
        n_opb = r_opb;
        n_prod = r_prod;
        n_acc = r_acc;
        n_m_data = r_m_data;
        n_m_valid = r_m_valid;
        p_we = 1'b0;
        p_waddr = {r_sub, r_last};
        p_wdata = add_sum;
        p_re = 1'b0;
        p_raddr = {r_sub, r_last};
        c_we = 1'b0;
        c_waddr = r_sub;
        c_wdata = add_sum;
        c_re = 1'b0;
        c_raddr = r_sub;

        // The receiver takes the pending result.
        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        // Register write.
        if (psel && penable && pwrite && (paddr[2] == REG_VERTEX_COUNT)) begin
            n_vc = pwdata[VC_W-1:0];
        end

        case (r_state)
            // Zero both stores, one entry per cycle.
            S_CLEAR: begin
                p_we = 1'b1;
                p_waddr = r_clr;
                p_wdata = '0;
                c_we = 1'b1;
                c_waddr = r_clr[MAX_VERTICES-1:0];
                c_wdata = '0;
                n_top = '0;
                if (r_clr == '1) begin
                    n_state = r_go_init ? S_INIT : S_IDLE;
                end else begin
                    n_clr = r_clr + PATH_AW'(1);
                end
            end
            // Wait for a request.
            S_IDLE: begin
                if (s_fire) begin
                    case (cmd)
                        CMD_LOAD: begin
                            for (int i = 0; i < MAX_VERTICES; i++) begin
                                if (32'(s_axis_tdata[VERTEX_LSB +: VERTEX_W]) == i) begin
                                    n_adj[i] = row_in;
                                end
                            end
                        end
                        CMD_RUN: begin
                            n_clr = '0;
                            n_go_init = 1'b1;
                            n_state = S_CLEAR;
                        end
                        CMD_QUERY: begin
                            n_first = q_first;
                            n_second = q_second;
                            n_state = S_QA;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // Seed a one-vertex path at every anchor.
            S_INIT: begin
                if (n_used == '0) begin
                    n_state = S_IDLE;
                end else begin
                    p_we = 1'b1;
                    p_waddr = {t_set'(1) << r_top, r_top};
                    p_wdata = COUNT_W'(1);
                    if (VW'(r_top) == n_m1) begin
                        n_top = '0;
                        n_sub = t_set'(1);
                        n_last = '0;
                        n_state = S_WAYS_RD;
                    end else begin
                        n_top = r_top + LW'(1);
                    end
                end
            end
            // Fetch the path count and the row of its last vertex.
            S_WAYS_RD: begin
                p_re = 1'b1;
                n_row = r_adj[r_last];
                n_j = '0;
                n_state = S_WAYS_LD;
            end
            S_WAYS_LD: begin
                n_ways = p_rdata;
                n_state = S_J;
            end
            // Extend the path through each lower unused neighbor.
            S_J: begin
                if (r_j == r_top) begin
                    if (r_row[r_top]) begin
                        c_re = 1'b1;
                        n_state = S_C_WR;
                    end else begin
                        n_state = S_LAST;
                    end
                end else if (!r_sub[r_j] && r_row[r_j]) begin
                    p_re = 1'b1;
                    p_raddr = j_addr;
                    n_state = S_J_WR;
                end else begin
                    n_j = r_j + LW'(1);
                end
            end
            S_J_WR: begin
                p_we = 1'b1;
                p_waddr = j_addr;
                n_j = r_j + LW'(1);
                n_state = S_J;
            end
            // Close the cycle back to the anchor.
            S_C_WR: begin
                c_we = 1'b1;
                n_state = S_LAST;
            end
            // Next last vertex, or hand the cover count to higher anchors.
            S_LAST: begin
                if (r_last == r_top) begin
                    if (VW'(r_top) < n_m1) begin
                        c_re = 1'b1;
                        n_k = r_top + LW'(1);
                        n_state = S_KLD;
                    end else begin
                        n_state = S_NEXT;
                    end
                end else begin
                    n_last = r_last + LW'(1);
                    n_state = S_WAYS_RD;
                end
            end
            S_KLD: begin
                n_ways = c_rdata;
                n_state = S_K;
            end
            S_K: begin
                p_re = 1'b1;
                p_raddr = k_addr;
                n_state = S_K_WR;
            end
            S_K_WR: begin
                p_we = 1'b1;
                p_waddr = k_addr;
                if (VW'(r_k) == n_m1) begin
                    n_state = S_NEXT;
                end else begin
                    n_k = r_k + LW'(1);
                    n_state = S_K;
                end
            end
            // Next subset under this anchor, or the next anchor.
            S_NEXT: begin
                n_last = '0;
                if (r_sub == sub_full) begin
                    if (VW'(r_top) == n_m1) begin
                        n_state = S_IDLE;
                    end else begin
                        n_top = r_top + LW'(1);
                        n_sub = t_set'(1) << (r_top + LW'(1));
                        n_state = S_WAYS_RD;
                    end
                end else begin
                    n_sub = r_sub + t_set'(1);
                    n_state = S_WAYS_RD;
                end
            end
            // Query: fetch one or two cover counts.
            S_QA: begin
                c_re = 1'b1;
                c_raddr = (r_first == '0) ? r_second : r_first;
                n_state = S_QB;
            end
            S_QB: begin
                n_opa = c_rdata;
                if ((r_first == '0) || (r_second == '0)) begin
                    n_acc = c_rdata;
                    n_state = S_OUT;
                end else begin
                    c_re = 1'b1;
                    c_raddr = r_second;
                    n_state = S_QC;
                end
            end
            S_QC: begin
                n_opb = c_rdata;
                n_state = S_M1;
            end
            // Low 64 bits of the product from three partial products.
            S_M1: begin
                n_prod = mul_p;
                n_state = S_M2;
            end
            S_M2: begin
                n_acc = r_prod;
                n_prod = mul_p;
                n_state = S_M3;
            end
            S_M3: begin
                n_acc = add_sum;
                n_prod = mul_p;
                n_state = S_M4;
            end
            S_M4: begin
                n_acc = add_sum;
                n_state = S_OUT;
            end
            // Hand the result to the output register once it is free.
            S_OUT: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_data = r_acc;
                    n_m_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_go_init <= 1'b0;
            r_clr <= '0;
            r_vc <= VC_RESET;
            r_m_valid <= 1'b0;
            for (int i = 0; i < MAX_VERTICES; i++) begin
                r_adj[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_go_init <= n_go_init;
            r_clr <= n_clr;
            r_vc <= n_vc;
            r_m_valid <= n_m_valid;
            r_adj <= n_adj;
            r_top <= n_top;
            r_last <= n_last;
            r_j <= n_j;
            r_k <= n_k;
            r_sub <= n_sub;
            r_row <= n_row;
            r_first <= n_first;
            r_second <= n_second;
            r_ways <= n_ways;
            r_opa <= n_opa;
            r_opb <= n_opb;
            r_prod <= n_prod;
            r_acc <= n_acc;
            r_m_data <= n_m_data;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata = r_m_data;

    // Register read and a port that never waits.
    assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? APB_DW'(r_vc) : '0;
    assign pready = 1'b1;

endmodule

// ===== design/sccc_ram.sv =====
// Generic simple dual-port RAM: one write port and one registered read port.
// Used for the partial-cycle and cover count stores. No dependencies.
module sccc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/sccc_checker.sv =====
// Port-level checks for the subset cycle cover counter, bound to the top level.
// Depends on sccc_pkg and subset_cycle_cover_counter_top.
module sccc_checker
    import sccc_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [S_TUSER_W-1:0] s_axis_tuser,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed under stall");

    // The store clearing sweep follows reset, so no request is taken at once.
    a_clear_after_reset: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !s_axis_tready)
        else $error("request taken before the clearing sweep");

    // A run request makes the block busy.
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_RUN) |=> !s_axis_tready)
        else $error("ready right after a run request");

    // Requests other than queries never produce a result.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser != CMD_QUERY) && !m_axis_tvalid
        |=> !m_axis_tvalid)
        else $error("result without a query");

    // A new result only comes out of query work.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared while idle");

endmodule

bind subset_cycle_cover_counter_top sccc_checker u_sccc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);

// ===== tb/sv/tb_subset_cycle_cover_counter_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for subset_cycle_cover_counter_top: directed table, then random phases.
// Predicts every query answer with its own cycle cover count and compares the output stream.
// Depends on sccc_pkg and the RTL of subset_cycle_cover_counter_top.
module tb_subset_cycle_cover_counter_top;
    import sccc_pkg::*;

    localparam int NV          = 8;
    localparam int CYCLE_LIMIT = 4_000_000;
    // Command code that the block leaves unused.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // One row of the directed request table.
    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [VERTEX_W-1:0] vertex;
        logic [ROW_W-1:0]    row;
        logic [QUERY_W-1:0]  mask;
        bit                  typed;
        logic [COUNT_W-1:0]  count;
    } t_request_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [APB_AW-1:0]    paddr = '0;
    logic [APB_DW-1:0]    pwdata = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    // Predictor state: rows, partial cycle counts, cover counts and the size register.
    logic [ROW_W-1:0]   adj_rows [NV];
    logic [COUNT_W-1:0] partial_ways [(1 << NV) * NV];
    logic [COUNT_W-1:0] cover_ways [1 << NV];
    logic [VC_W-1:0]    vertex_count_reg = VC_RESET;

    logic [COUNT_W-1:0] pending_counts [$];
    logic [COUNT_W-1:0] oldest_count;
    bit                 failed = 1'b0;
    bit                 run_in_flight = 1'b0;
    int                 last_run_cycles = 0;
    int                 tx_idle_pct = 0;
    int                 rx_stall_pct = 0;
    int                 cycles_elapsed = 0;

    t_request_row directed_rows [0:20] = '{
        // Queries before any run answer zero.
        '{CMD_QUERY,  3'd0, 8'h00, 8'h00, 1'b1, 64'd0},
        '{CMD_QUERY,  3'd7, 8'hFF, 8'hFF, 1'b1, 64'd0},
        // The unused code produces nothing.
        '{CMD_UNUSED, 3'd7, 8'hFF, 8'hFF, 1'b0, 64'd0},
        '{CMD_LOAD,   3'd0, 8'h01, 8'h00, 1'b0, 64'd0},
        '{CMD_LOAD,   3'd1, 8'h04, 8'hFF, 1'b0, 64'd0},
        '{CMD_LOAD,   3'd2, 8'h03, 8'h00, 1'b0, 64'd0},
        '{CMD_LOAD,   3'd3, 8'hFF, 8'h00, 1'b0, 64'd0},
        '{CMD_LOAD,   3'd4, 8'h10, 8'h00, 1'b0, 64'd0},
        '{CMD_LOAD,   3'd5, 8'h80, 8'h00, 1'b0, 64'd0},
        '{CMD_LOAD,   3'd6, 8'h40, 8'h00, 1'b0, 64'd0},
        '{CMD_LOAD,   3'd7, 8'hFF, 8'h00, 1'b0, 64'd0},
        '{CMD_RUN,    3'd5, 8'hAA, 8'h55, 1'b0, 64'd0},
        '{CMD_QUERY,  3'd0, 8'h00, 8'h00, 1'b0, 64'd0},
        '{CMD_QUERY,  3'd0, 8'h00, 8'hFF, 1'b0, 64'd0},
        '{CMD_QUERY,  3'd0, 8'h00, 8'h01, 1'b0, 64'd0},
        '{CMD_QUERY,  3'd0, 8'h00, 8'h06, 1'b0, 64'd0},
        '{CMD_QUERY,  3'd0, 8'h00, 8'h0F, 1'b0, 64'd0},
        '{CMD_QUERY,  3'd0, 8'h00, 8'hF0, 1'b0, 64'd0},
        '{CMD_QUERY,  3'd0, 8'h00, 8'hAA, 1'b0, 64'd0},
        '{CMD_QUERY,  3'd0, 8'h00, 8'h55, 1'b0, 64'd0},
        '{CMD_QUERY,  3'd0, 8'h00, 8'h81, 1'b0, 64'd0}
    };

    subset_cycle_cover_counter_top #(
        .MAX_VERTICES(NV)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #4 i_clk = ~i_clk;

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles_elapsed++;
        if (cycles_elapsed > CYCLE_LIMIT) begin
            $display("subset_cycle_cover_counter_top regression: fail");
            $finish;
        end
    end

    // Receiver backpressure, redrawn every cycle.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Compare each accepted result with the oldest predicted count.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_counts.size() == 0) begin
                $error("count: expected none, actual %h", m_axis_tdata);
                failed = 1'b1;
            end else begin
                oldest_count = pending_counts.pop_front();
                if (m_axis_tdata !== oldest_count) begin
                    $error("count: expected %h, actual %h", oldest_count, m_axis_tdata);
                    failed = 1'b1;
                end
            end
        end
    end

    // Vertices that a run or query uses: the register saturates at the build maximum.
    function automatic int vertices_in_use();
        return (vertex_count_reg > NV) ? NV : int'(vertex_count_reg);
    endfunction

    // Recompute every subset's cover count. Cycles are anchored at their highest vertex.
    function automatic void recount_covers();
        int n;
        logic [COUNT_W-1:0] ways;
        logic [ROW_W-1:0] row;
        n = vertices_in_use();
        foreach (partial_ways[i]) partial_ways[i] = '0;
        foreach (cover_ways[i]) cover_ways[i] = '0;
        for (int top = 0; top < n; top++) begin
            partial_ways[(1 << top) * NV + top] = 64'd1;
        end
        for (int top = 0; top < n; top++) begin
            for (int sub = (1 << top); sub < (2 << top); sub++) begin
                for (int last = 0; last <= top; last++) begin
                    ways = partial_ways[sub * NV + last];
                    row = adj_rows[last];
                    // Extend through a lower unused vertex, or close back to the anchor.
                    for (int j = 0; j < top; j++) begin
                        if (!sub[j] && row[j]) begin
                            partial_ways[(sub | (1 << j)) * NV + j] += ways;
                        end
                    end
                    if (row[top]) begin
                        cover_ways[sub] += ways;
                    end
                end
                // A finished cover of sub may be followed by a cycle anchored higher up.
                for (int k = top + 1; k < n; k++) begin
                    partial_ways[(sub | (1 << k)) * NV + k] += cover_ways[sub];
                end
            end
        end
    endfunction

    // Answer to a split query under the current vertex count.
    function automatic logic [COUNT_W-1:0] split_count(input logic [QUERY_W-1:0] mask);
        logic [NV-1:0] all_used;
        logic [NV-1:0] first_group;
        logic [NV-1:0] second_group;
        all_used = NV'((1 << vertices_in_use()) - 1);
        first_group = mask & all_used;
        second_group = all_used & ~first_group;
        if (first_group == '0) begin
            return cover_ways[second_group];
        end else if (second_group == '0) begin
            return cover_ways[first_group];
        end
        return cover_ways[first_group] * cover_ways[second_group];
    endfunction

    // Apply one accepted request to the predictor.
    function automatic void absorb_request(input logic [CMD_W-1:0] cmd,
                                           input logic [VERTEX_W-1:0] vertex,
                                           input logic [ROW_W-1:0] row,
                                           input logic [QUERY_W-1:0] mask,
                                           input bit typed,
                                           input logic [COUNT_W-1:0] typed_count);
        int n;
        n = vertices_in_use();
        case (cmd)
            CMD_LOAD: begin
                adj_rows[vertex] = row;
            end
            CMD_RUN: begin
                recount_covers();
                run_in_flight = 1'b1;
                last_run_cycles = 2048 + (1 << n) * n * (2 * n + 6) + 256;
            end
            CMD_QUERY: begin
                pending_counts = {pending_counts, (typed ? typed_count : split_count(mask))};
                run_in_flight = 1'b0;
            end
            default: begin
            end
        endcase
    endfunction

    // Offer one request, with random sender gaps in front, and wait for its handshake.
    task automatic send_request(input logic [CMD_W-1:0] cmd,
                                input logic [VERTEX_W-1:0] vertex,
                                input logic [ROW_W-1:0] row,
                                input logic [QUERY_W-1:0] mask,
                                input bit typed,
                                input logic [COUNT_W-1:0] typed_count);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = cmd;
        s_axis_tdata = '0;
        s_axis_tdata[VERTEX_LSB +: VERTEX_W] = vertex;
        s_axis_tdata[ROW_LSB +: ROW_W] = row;
        s_axis_tdata[QUERY_LSB +: QUERY_W] = mask;
        do @(posedge i_clk); while (!s_axis_tready);
        absorb_request(cmd, vertex, row, mask, typed, typed_count);
        @(negedge i_clk);
    endtask

    // Hold the sender until every predicted count has come back.
    task automatic wait_for_counts();
        s_axis_tvalid = 1'b0;
        while (pending_counts.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Wait until the block is idle: a run with no query after it gives no result to wait on.
    task automatic drain_block();
        wait_for_counts();
        repeat (run_in_flight ? last_run_cycles : 16) @(negedge i_clk);
        run_in_flight = 1'b0;
    endtask

    // Register write: setup cycle, then access cycle.
    task automatic write_vertex_count(input logic [VC_W-1:0] value);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {REG_VERTEX_COUNT, 2'b00};
        pwdata = APB_DW'(value);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        vertex_count_reg = value;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // Random byte with the all-zero and all-one values drawn often.
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // One phase: set the size, query the stale counts, then load-run-query episodes
    // with some stray requests mixed in.
    task automatic run_phase(input logic [VC_W-1:0] vc, input int tx_pct, input int rx_pct,
                             input int budget);
        int n;
        int issued;
        drain_block();
        write_vertex_count(vc);
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        n = vertices_in_use();
        issued = 2;
        repeat (2) send_request(CMD_QUERY, 3'($urandom), rand_byte(), rand_byte(), 1'b0, '0);
        while (issued < budget) begin
            if ($urandom_range(99) < 15) begin
                case ($urandom_range(2))
                    0: send_request(CMD_LOAD, 3'($urandom), rand_byte(), rand_byte(), 1'b0, '0);
                    1: send_request(CMD_QUERY, 3'($urandom), rand_byte(), rand_byte(), 1'b0,
                                    '0);
                    default: begin
                        send_request(CMD_UNUSED, 3'($urandom), rand_byte(), rand_byte(), 1'b0,
                                     '0);
                        issued--;
                    end
                endcase
                issued++;
            end else begin
                for (int v = 0; v < n; v++) begin
                    send_request(CMD_LOAD, 3'(v), rand_byte(), rand_byte(), 1'b0, '0);
                end
                // Rows past the vertex count are stored but never used.
                if (n < NV) begin
                    send_request(CMD_LOAD, 3'($urandom_range(NV - 1, n)), rand_byte(),
                                 rand_byte(), 1'b0, '0);
                    issued++;
                end
                send_request(CMD_RUN, 3'($urandom), rand_byte(), rand_byte(), 1'b0, '0);
                issued += n + 1;
                repeat ($urandom_range(6, 2)) begin
                    send_request(CMD_QUERY, 3'($urandom), rand_byte(), rand_byte(), 1'b0, '0);
                    issued++;
                end
                if ($urandom_range(4) == 0) begin
                    wait_for_counts();
                end
            end
        end
    endtask

    initial begin
        foreach (adj_rows[i]) adj_rows[i] = '0;
        foreach (partial_ways[i]) partial_ways[i] = '0;
        foreach (cover_ways[i]) cover_ways[i] = '0;

        // Hold the synchronous reset, then release it.
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table at the reset size of eight vertices.
        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].cmd, directed_rows[i].vertex, directed_rows[i].row,
                         directed_rows[i].mask, directed_rows[i].typed,
                         directed_rows[i].count);
        end
        wait_for_counts();

        // Random phases across sizes and idling patterns.
        run_phase(4'd4, 0, 0, 12);
        run_phase(4'd15, 64, 0, 10);
        run_phase(4'd1, 0, 64, 12);
        run_phase(4'd0, 7, 7, 8);
        run_phase(4'd6, 7, 7, 14);
        run_phase(4'd8, 0, 0, 12);
        drain_block();

        if (failed) begin
            $display("subset_cycle_cover_counter_top regression: fail");
        end else begin
            $display("subset_cycle_cover_counter_top regression: pass");
        end
        $finish;
    end

endmodule
